// ===== rtl/frpd_pkg.sv =====
// Shared types and constants for the packet dropper.
`timescale 1ns / 1ps
package frpd_pkg;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [6:0]  POS_MAX    = 7'd127;

    localparam logic [2:0] REG_IP_VERSION = 3'd0;
    localparam logic [2:0] REG_IPV4_ADDR  = 3'd1;
    localparam logic [2:0] REG_IPV6_HIGH  = 3'd2;
    localparam logic [2:0] REG_IPV6_LOW   = 3'd3;
    localparam logic [2:0] REG_PORT       = 3'd4;
    localparam logic [2:0] REG_LOSS       = 3'd5;
    localparam logic [2:0] REG_PROTO_EN   = 3'd6;
    localparam logic [2:0] REG_DIR_EN     = 3'd7;

    typedef struct packed {
        logic [2:0]  ip_version;
        logic [31:0] ipv4_addr;
        logic [63:0] ipv6_high;
        logic [63:0] ipv6_low;
        logic [15:0] port;
        logic [6:0]  loss;
        logic [1:0]  proto_en;
        logic [1:0]  dir_en;
    } t_cfg;

    // Classification of one frame, handed from parser to decision stage.
    typedef struct packed {
        logic        matched;
        logic        l3_version;
        logic        l4_proto;
        logic [15:0] remote_port;
        logic [31:0] rand_value;
    } t_class;

    // Drop threshold floor(p * 0xFFFFFFFF / 100) for loss percentage p.
    function automatic logic [31:0] f_threshold(input logic [6:0] p);
        logic [63:0] prod;
        prod = 64'(p) * 64'hFFFF_FFFF;
        return 32'(prod / 64'd100);
    endfunction
endpackage

// ===== rtl/frpd_if.sv =====
// Valid/ready channel interfaces for frame bytes and verdicts.
`timescale 1ns / 1ps
interface frpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       egress_dir;
    logic [31:0] rand_value;
    modport source (output valid, frame_byte, last_byte, egress_dir, rand_value, input ready);
    modport sink   (input valid, frame_byte, last_byte, egress_dir, rand_value, output ready);
endinterface

interface frpd_out_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic        matched;
    logic        l3_version;
    logic        l4_proto;
    logic [15:0] remote_port;
    modport source (output valid, drop, matched, l3_version, l4_proto, remote_port, input ready);
    modport sink   (input valid, drop, matched, l3_version, l4_proto, remote_port, output ready);
endinterface

// ===== rtl/filtered_random_packet_dropper_unit.sv =====
// Top level of the filtered random packet dropper.
`timescale 1ns / 1ps
// Takes an Ethernet frame one byte per clock and gives one verdict per frame,
// registered in the parser, then queued. Bytes are accepted every cycle while
// the four-entry verdict queue has room; only output back-pressure can stall
// the input. The drop threshold comes from a 101-entry table.
module filtered_random_packet_dropper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    frpd_in_if.sink     in_ch,
    frpd_out_if.source  out_ch
);
    import frpd_pkg::*;

    t_cfg        r_cfg;
    logic [31:0] thr_rom [101];
    logic [31:0] thr;
    logic        push, room, take;
    t_class      cls;

    // threshold per loss percentage, folded to constants
    for (genvar g = 0; g <= 100; g++) begin : g_thr
        assign thr_rom[g] = f_threshold(7'(g));
    end

    assign thr = thr_rom[r_cfg.loss];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ip_version: 3'd0, ipv4_addr: 32'd0, ipv6_high: 64'd0,
                       ipv6_low: 64'd0, port: 16'd0, loss: 7'd100,
                       proto_en: 2'd3, dir_en: 2'd2};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IP_VERSION: r_cfg.ip_version <= i_cfg_data[2:0];
                REG_IPV4_ADDR:  r_cfg.ipv4_addr  <= i_cfg_data[31:0];
                REG_IPV6_HIGH:  r_cfg.ipv6_high  <= i_cfg_data;
                REG_IPV6_LOW:   r_cfg.ipv6_low   <= i_cfg_data;
                REG_PORT:       r_cfg.port       <= i_cfg_data[15:0];
                REG_LOSS: begin
                    // saturate at 100
                    r_cfg.loss <= (i_cfg_data[6:0] > 7'd100) ? 7'd100 : i_cfg_data[6:0];
                end
                REG_PROTO_EN:   r_cfg.proto_en   <= i_cfg_data[1:0];
                REG_DIR_EN:     r_cfg.dir_en     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = room;
    assign take = in_ch.valid && room;

    frpd_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_take(take),
        .i_byte(in_ch.frame_byte), .i_last(in_ch.last_byte),
        .i_egr(in_ch.egress_dir), .i_rand(in_ch.rand_value),
        .o_push(push), .o_class(cls)
    );

    frpd_backend u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_thr(thr), .i_push(push),
        .i_class(cls), .o_room(room), .out(out_ch)
    );
endmodule

// ===== rtl/frpd_parser.sv =====
// Front part: byte parser and filter classification.
`timescale 1ns / 1ps
module frpd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  frpd_pkg::t_cfg i_cfg,
    input  logic           i_take,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic           i_egr,
    input  logic [31:0]    i_rand,
    output logic           o_push,
    output frpd_pkg::t_class o_class
);
    import frpd_pkg::*;

    logic [6:0]  r_pos, n_pos;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_nproto, n_nproto;
    logic [6:0]  r_l4s, n_l4s;
    logic [1:0]  r_aok, n_aok;
    logic [15:0] r_sport, n_sport, r_dport, n_dport;
    logic        r_rej, n_rej;
    logic        r_push;
    t_class      r_class, n_class;

    logic [7:0]  want;
    logic [6:0]  p;
    logic        is4, is6;
    logic [7:0]  len;
    logic [7:0]  need;
    logic [15:0] hport;
    logic        m;
    logic [3:0]  k4;
    logic [3:0]  k6;
    logic [127:0] v6;

    always_comb begin
        p = r_pos;
        n_pos = r_pos;
        n_etype = r_etype;
        n_nproto = r_nproto;
        n_l4s = r_l4s;
        n_aok = r_aok;
        n_sport = r_sport;
        n_dport = r_dport;
        n_rej = r_rej;
        v6 = {i_cfg.ipv6_high, i_cfg.ipv6_low};
        k4 = 4'(p - 7'd26);
        k6 = 4'(p - 7'd22);
        want = 8'h00;
        if (p == 7'd12) n_etype[15:8] = i_byte;
        if (p == 7'd13) begin
            n_etype[7:0] = i_byte;
            if ({r_etype[15:8], i_byte} == ETYPE_IPV6) n_l4s = 7'd54;
        end
        is4 = (p >= 7'd14) && (r_etype == ETYPE_IPV4);
        is6 = (p >= 7'd14) && (r_etype == ETYPE_IPV6);
        if (is4) begin
            if (p == 7'd14) begin
                n_rej = i_byte[3:0] < 4'd5;
                n_l4s = 7'd14 + {1'b0, i_byte[3:0], 2'b00};
            end
            if (p == 7'd23) n_nproto = i_byte;
            if (p >= 7'd26 && p < 7'd34) begin
                want = i_cfg.ipv4_addr[8 * (3 - k4[1:0]) +: 8];
                if (i_byte != want) n_aok[p >= 7'd30] = 1'b0;
            end
        end
        if (is6) begin
            if (p == 7'd20) n_nproto = i_byte;
            if (p >= 7'd22 && p < 7'd54) begin
                want = v6[8 * (15 - k6) +: 8];
                if (i_byte != want) n_aok[p >= 7'd38] = 1'b0;
            end
        end
        if (is4 || is6) begin
            // port bytes sit at the L4 start known before this byte
            if (p == r_l4s)          n_sport[15:8] = i_byte;
            if (p == r_l4s + 7'd1)   n_sport[7:0]  = i_byte;
            if (p == r_l4s + 7'd2)   n_dport[15:8] = i_byte;
            if (p == r_l4s + 7'd3)   n_dport[7:0]  = i_byte;
        end
        if (r_pos != POS_MAX) n_pos = r_pos + 7'd1;

        // verdict uses updated state
        len = {1'b0, r_pos} + 8'd1;
        hport = i_egr ? n_dport : n_sport;
        need = (n_nproto == PROTO_TCP) ? 8'd20 : 8'd8;
        m = i_cfg.dir_en[i_egr] && len >= 8'd14;
        n_class = '0;
        if (n_etype == ETYPE_IPV4) begin
            if (i_cfg.ip_version == 3'd6 || len < 8'd34 || n_rej) m = 1'b0;
            if (i_cfg.ipv4_addr != 32'd0 && !n_aok[i_egr]) m = 1'b0;
        end else if (n_etype == ETYPE_IPV6) begin
            if (i_cfg.ip_version == 3'd4 && i_cfg.ipv4_addr != 32'd0) m = 1'b0;
            if (len < 8'd54) m = 1'b0;
            if (i_cfg.ip_version == 3'd6 && ((i_cfg.dir_en[0] && !n_aok[0]) ||
                (i_cfg.dir_en[1] && !n_aok[1]))) m = 1'b0;
        end else begin
            m = 1'b0;
        end
        if (n_nproto == PROTO_TCP) begin
            if (!i_cfg.proto_en[0]) m = 1'b0;
        end else if (n_nproto == PROTO_UDP) begin
            if (!i_cfg.proto_en[1]) m = 1'b0;
        end else begin
            m = 1'b0;
        end
        if (len < {1'b0, n_l4s} + need) m = 1'b0;
        if (i_cfg.port != 16'd0 && i_cfg.port != hport) m = 1'b0;
        n_class.matched = m;
        n_class.l3_version = m && (n_etype == ETYPE_IPV6);
        n_class.l4_proto = m && (n_nproto == PROTO_UDP);
        n_class.remote_port = m ? hport : 16'd0;
        n_class.rand_value = i_rand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_etype <= '0; r_nproto <= '0; r_l4s <= '0;
            r_aok <= 2'b11; r_sport <= '0; r_dport <= '0; r_rej <= 1'b0;
            r_push <= 1'b0;
        end else begin
            r_push <= i_take && i_last;
            if (i_take) begin
                if (i_last) begin
                    r_pos <= '0; r_etype <= '0; r_nproto <= '0; r_l4s <= '0;
                    r_aok <= 2'b11; r_sport <= '0; r_dport <= '0; r_rej <= 1'b0;
                end else begin
                    r_pos <= n_pos; r_etype <= n_etype; r_nproto <= n_nproto;
                    r_l4s <= n_l4s; r_aok <= n_aok; r_sport <= n_sport;
                    r_dport <= n_dport; r_rej <= n_rej;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last) r_class <= n_class;
    end

    assign o_push = r_push;
    assign o_class = r_class;
endmodule

// ===== rtl/frpd_backend.sv =====
// Back part: verdict queue and drop decision.
`timescale 1ns / 1ps
module frpd_backend (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_thr,
    input  logic             i_push,
    input  frpd_pkg::t_class i_class,
    output logic             o_room,
    frpd_out_if.source       out
);
    import frpd_pkg::*;

    t_class      r_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        pop;
    t_class      head;

    assign head = r_mem[r_rp];
    assign pop = out.valid && out.ready;
    // two slots kept free: one for the verdict in the parser register, one for a frame ending now
    assign o_room = r_cnt <= 3'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_class;
    end

    assign out.valid = r_cnt != 3'd0;
    assign out.matched = head.matched;
    assign out.drop = head.matched && head.rand_value <= i_thr;
    assign out.l3_version = head.l3_version;
    assign out.l4_proto = head.l4_proto;
    assign out.remote_port = head.remote_port;

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 3'd4) else $error("verdict queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("verdict count out of range");
    a_drop_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out.valid && out.drop |-> out.matched) else $error("drop without match");
endmodule
